// ----- rtl/core/tard_pkg.sv -----
// Shared types and codes for the timed actuator register device.
package tard_pkg;

    localparam int unsigned DelayW = 16;
    localparam int unsigned AddrW  = 16;
    localparam int unsigned DataW  = 16;
    localparam int unsigned CfgIdxW = 2;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ADDR  = 2'd1,
        ST_BAD_VALUE = 2'd2
    } status_t;

    // Actuator phase; end A is bottom/closed, end B is top/open
    typedef enum logic [2:0] {
        PH_END_A = 3'd0,
        PH_TO_B  = 3'd1,
        PH_END_B = 3'd2,
        PH_TO_A  = 3'd3,
        PH_IDLE  = 3'd4
    } phase_t;

    // Actuator command register values
    localparam logic [1:0] ACT_STOP = 2'd0;
    localparam logic [1:0] ACT_TO_B = 2'd1;
    localparam logic [1:0] ACT_TO_A = 2'd2;

    // Holding register addresses
    localparam logic [AddrW-1:0] ADDR_LIFT  = 16'd0;
    localparam logic [AddrW-1:0] ADDR_VALVE = 16'd1;
    localparam logic [AddrW-1:0] ADDR_RUN   = 16'd2;
    localparam logic [AddrW-1:0] ADDR_MODE  = 16'd3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_LIFT_UP     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LIFT_DOWN   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_VALVE_OPEN  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_VALVE_CLOSE = 2'd3;

    localparam logic [DelayW-1:0] DELAY_RESET = 16'd1000;

    // Control from the decode logic to one actuator
    typedef struct packed {
        logic       cmd_wr;
        logic [1:0] cmd_val;
        logic       tick;
    } act_ctrl_t;

endpackage

// ----- rtl/core/tard_req_if.sv -----
// Request channel: command, address and write value with valid/ready.
interface tard_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] reg_address;
    logic [15:0] write_value;

    modport source (output valid, output command, output reg_address,
                    output write_value, input ready);
    modport sink   (input valid, input command, input reg_address,
                    input write_value, output ready);
endinterface

// ----- rtl/core/tard_rsp_if.sv -----
// Response channel: status, read data, actuator states and position flags.
interface tard_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] read_data;
    logic [2:0] lift_state;
    logic [2:0] valve_position;
    logic       at_top_flag;
    logic       at_bottom_flag;
    logic       open_flag;
    logic       closed_flag;

    modport source (output valid, output status, output read_data,
                    output lift_state, output valve_position,
                    output at_top_flag, output at_bottom_flag,
                    output open_flag, output closed_flag, input ready);
    modport sink   (input valid, input status, input read_data,
                    input lift_state, input valve_position,
                    input at_top_flag, input at_bottom_flag,
                    input open_flag, input closed_flag, output ready);
endinterface

// ----- rtl/core/timed_actuator_register_device.sv -----
// Top level of the timed actuator register device.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-------------------------------------------
//  req     | in  | valid / ready   | command, reg_address, write_value
//  rsp     | out | valid / ready   | status, read_data, lift_state,
//          |     |                 | valve_position, four position flags
//  cfg     | in  | cfg_we          | cfg_index, cfg_wdata (four delay registers)
//
//  One request per cycle sustained while rsp is not stalled; an accepted
//  request passes the input register, then the result register, before
//  its result is valid on rsp.
//  The work per request is one decode plus the two actuator updates, all
//  between the input register and the result register.
//  Reset is asynchronous, active low: both actuators at bottom/closed,
//  command and mode registers zero, delays at 1000 ticks.
//  A stalled rsp holds the result; req stays ready while the input
//  register is empty or moves forward in the same cycle.
module timed_actuator_register_device
(
    input  logic                         clk,
    input  logic                         rst_n,
    tard_req_if.sink                     req,
    tard_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [tard_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [tard_pkg::DataW-1:0]   cfg_wdata
);
    import tard_pkg::*;

    // delay registers
    logic [DelayW-1:0] lift_up_reg, lift_down_reg;
    logic [DelayW-1:0] valve_open_reg, valve_close_reg;

    // input register
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [AddrW-1:0]  in_addr_reg;
    logic [DataW-1:0]  in_data_reg;

    // run and mode bits
    logic              run_reg, run_next;
    logic              mode_reg, mode_next;

    // result register
    logic              out_valid_reg;
    status_t           out_status_reg, status_next;
    logic [1:0]        out_rdata_reg, rdata_next;
    phase_t            out_lift_reg, out_valve_reg;

    logic              advance;
    logic              val_ok_act, val_ok_bit;
    act_ctrl_t         lift_ctrl, valve_ctrl;
    phase_t            lift_phase, lift_phase_next;
    phase_t            valve_phase, valve_phase_next;
    logic [1:0]        lift_cmd, valve_cmd;

    // move the input register forward when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_up_reg     <= DELAY_RESET;
            lift_down_reg   <= DELAY_RESET;
            valve_open_reg  <= DELAY_RESET;
            valve_close_reg <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIFT_UP:     lift_up_reg     <= cfg_wdata;
                CFG_LIFT_DOWN:   lift_down_reg   <= cfg_wdata;
                CFG_VALVE_OPEN:  valve_open_reg  <= cfg_wdata;
                CFG_VALVE_CLOSE: valve_close_reg <= cfg_wdata;
                default:         lift_up_reg     <= lift_up_reg;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_cmd_reg  <= cmd_t'(req.command);
            in_addr_reg <= req.reg_address;
            in_data_reg <= req.write_value;
        end
    end

    // decode: status, read data and the per-actuator controls
    assign val_ok_act = (in_data_reg <= DataW'(2));
    assign val_ok_bit = (in_data_reg <= DataW'(1));

    always_comb
    begin
        status_next = ST_OK;
        rdata_next  = 2'd0;
        run_next    = run_reg;
        mode_next   = mode_reg;
        lift_ctrl   = '0;
        valve_ctrl  = '0;
        case (in_cmd_reg)
            CMD_WRITE:
            begin
                if (in_addr_reg == ADDR_LIFT)
                begin
                    if (val_ok_act)
                        lift_ctrl.cmd_wr = 1'b1;
                    else
                        status_next = ST_BAD_VALUE;
                end
                else if (in_addr_reg == ADDR_VALVE)
                begin
                    if (val_ok_act)
                        valve_ctrl.cmd_wr = 1'b1;
                    else
                        status_next = ST_BAD_VALUE;
                end
                else if (in_addr_reg == ADDR_RUN)
                begin
                    if (val_ok_bit)
                        run_next = in_data_reg[0];
                    else
                        status_next = ST_BAD_VALUE;
                end
                else if (in_addr_reg == ADDR_MODE)
                begin
                    if (val_ok_bit)
                        mode_next = in_data_reg[0];
                    else
                        status_next = ST_BAD_VALUE;
                end
                else
                begin
                    status_next = ST_BAD_ADDR;
                end
            end
            CMD_READ:
            begin
                // unknown addresses read as zero
                if (in_addr_reg == ADDR_LIFT)
                    rdata_next = lift_cmd;
                else if (in_addr_reg == ADDR_VALVE)
                    rdata_next = valve_cmd;
                else if (in_addr_reg == ADDR_RUN)
                    rdata_next = {1'b0, run_reg};
                else if (in_addr_reg == ADDR_MODE)
                    rdata_next = {1'b0, mode_reg};
            end
            CMD_TICK:
            begin
                lift_ctrl.tick  = 1'b1;
                valve_ctrl.tick = 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        lift_ctrl.cmd_val  = in_data_reg[1:0];
        valve_ctrl.cmd_val = in_data_reg[1:0];
    end

    tard_actuator u_lift
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .ctrl       (lift_ctrl),
        .delay_to_b (lift_up_reg),
        .delay_to_a (lift_down_reg),
        .phase      (lift_phase),
        .phase_next (lift_phase_next),
        .cmd        (lift_cmd)
    );

    tard_actuator u_valve
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .ctrl       (valve_ctrl),
        .delay_to_b (valve_open_reg),
        .delay_to_a (valve_close_reg),
        .phase      (valve_phase),
        .phase_next (valve_phase_next),
        .cmd        (valve_cmd)
    );

    // run and mode bits commit only with an advancing request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            mode_reg <= 1'b0;
        end
        else if (advance)
        begin
            run_reg  <= run_next;
            mode_reg <= mode_next;
        end
    end

    // result register: hold while stalled, load on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_rdata_reg  <= rdata_next;
            out_lift_reg   <= lift_phase_next;
            out_valve_reg  <= valve_phase_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_data      = out_rdata_reg;
    assign rsp.lift_state     = out_lift_reg;
    assign rsp.valve_position = out_valve_reg;
    assign rsp.at_top_flag    = (out_lift_reg == PH_END_B);
    assign rsp.at_bottom_flag = (out_lift_reg == PH_END_A);
    assign rsp.open_flag      = (out_valve_reg == PH_END_B);
    assign rsp.closed_flag    = (out_valve_reg == PH_END_A);

    // a held request is never dropped while the result side stalls
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_addr_reg))
        else $error("pending request lost while stalled");

    // every advancing request produces a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request produced no result");

    // the shown actuator states match the actuators after their request
    a_lift_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_lift_reg == lift_phase && out_valve_reg == valve_phase)
        else $error("reported actuator state differs from actuator");

endmodule

// ----- rtl/core/tard_actuator.sv -----
// One timed actuator: phase, travel countdown and command register.
module tard_actuator
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  tard_pkg::act_ctrl_t       ctrl,
    input  logic [15:0]               delay_to_b,
    input  logic [15:0]               delay_to_a,
    output tard_pkg::phase_t          phase,
    output tard_pkg::phase_t          phase_next,
    output logic [1:0]                cmd
);
    import tard_pkg::*;

    phase_t              phase_reg;
    logic [DelayW-1:0]   count_reg, count_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic                moving;

    assign moving = (phase_reg == PH_TO_B) || (phase_reg == PH_TO_A);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        if (advance && ctrl.cmd_wr)
        begin
            cmd_next = ctrl.cmd_val;
            case (ctrl.cmd_val)
                ACT_STOP:
                begin
                    count_next = '0;
                    if (moving)
                        phase_next = PH_IDLE;
                end
                ACT_TO_B:
                begin
                    if (phase_reg != PH_END_B && phase_reg != PH_TO_B)
                    begin
                        phase_next = PH_TO_B;
                        count_next = delay_to_b;
                    end
                end
                ACT_TO_A:
                begin
                    if (phase_reg != PH_END_A && phase_reg != PH_TO_A)
                    begin
                        phase_next = PH_TO_A;
                        count_next = delay_to_a;
                    end
                end
                default:
                begin
                    cmd_next = cmd_reg;
                end
            endcase
        end
        else if (advance && ctrl.tick && moving)
        begin
            // a countdown of zero or one ends the travel on this tick
            if (count_reg <= DelayW'(1))
            begin
                count_next = '0;
                phase_next = (phase_reg == PH_TO_B) ? PH_END_B : PH_END_A;
            end
            else
            begin
                count_next = count_reg - DelayW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_END_A;
            count_reg <= '0;
            cmd_reg   <= ACT_STOP;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign phase = phase_reg;
    assign cmd   = cmd_reg;

    // a stop always leaves the actuator at rest
    a_stop_rests: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctrl.cmd_wr && ctrl.cmd_val == ACT_STOP |=>
            !((phase_reg == PH_TO_B) || (phase_reg == PH_TO_A)))
        else $error("actuator still moving after stop");

    // a resting actuator keeps a zero countdown
    a_rest_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !moving |-> count_reg == '0)
        else $error("countdown nonzero while at rest");

    // travel toward end B completes on a tick at countdown zero or one
    a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctrl.tick && !ctrl.cmd_wr && phase_reg == PH_TO_B &&
            count_reg <= DelayW'(1) |=> phase_reg == PH_END_B)
        else $error("travel toward end B did not complete");

endmodule
